[rtl/websocket_frame_deframer_unmask_core_macros.svh]
// Assertion macros shared by the WebSocket deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/wsd_pkg.sv]
// Package with types and constants for the WebSocket deframer.
package wsd_pkg;

   localparam int LengthBitsDefault = 64;

   localparam logic [7:0] RsvMask     = 8'h70;
   localparam logic [6:0] LenShortMax = 7'd125;
   localparam logic [6:0] LenExt16    = 7'd126;
   localparam logic [2:0] ExtBytes16  = 3'd1;
   localparam logic [2:0] ExtBytes64  = 3'd7;
   localparam logic [1:0] KeyLastIdx  = 2'd3;

   typedef enum logic [2:0] {
      PHASE_HDR0,
      PHASE_HDR1,
      PHASE_EXT,
      PHASE_MASK,
      PHASE_PAY
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       final_fragment;
      logic       last_of_frame;
      logic       empty_frame;
      logic       reserved_bits_error;
   } result_type;

endpackage

[rtl/wsd_parser.sv]
// Frame header parser, length tracker and payload unmasker.
`include "websocket_frame_deframer_unmask_core_macros.svh"

module wsd_parser #(
   parameter int LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   output logic               res_fire,
   output wsd_pkg::result_type res
);
   import wsd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   mask_present_ff, mask_present_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [2:0]             ext_left_ff, ext_left_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   halted_ff, halted_in;

   logic                   key_done;
   logic [6:0]             len7;
   logic [7:0]             key_byte;
   logic [LENGTH_BITS-1:0] len_dec;

   assign len7     = data_byte[6:0];
   assign key_byte = 8'(key_ff >> {~idx_ff, 3'b000});
   assign len_dec  = length_ff - LENGTH_BITS'(1);

   always_comb begin
      phase_in        = phase_ff;
      fin_in          = fin_ff;
      opcode_in       = opcode_ff;
      mask_present_in = mask_present_ff;
      length_in       = length_ff;
      ext_left_in     = ext_left_ff;
      key_in          = key_ff;
      idx_in          = idx_ff;
      halted_in       = halted_ff;
      key_done        = 1'b0;
      res_fire        = 1'b0;
      res             = '0;
      if (step && !halted_ff) begin
         unique case (phase_ff)
            PHASE_HDR0: begin
               if ((data_byte & RsvMask) != 8'h00) begin
                  halted_in               = 1'b1;
                  res_fire                = 1'b1;
                  res.reserved_bits_error = 1'b1;
               end else begin
                  fin_in    = data_byte[7];
                  opcode_in = data_byte[3:0];
                  phase_in  = PHASE_HDR1;
               end
            end
            PHASE_HDR1: begin
               mask_present_in = data_byte[7];
               key_in          = '0;
               idx_in          = '0;
               if (len7 > LenShortMax) begin
                  length_in   = '0;
                  ext_left_in = (len7 == LenExt16) ? ExtBytes16 : ExtBytes64;
                  phase_in    = PHASE_EXT;
               end else begin
                  length_in = LENGTH_BITS'(len7);
                  if (data_byte[7]) begin
                     phase_in = PHASE_MASK;
                  end else begin
                     key_done = 1'b1;
                  end
               end
            end
            PHASE_EXT: begin
               length_in = {length_ff[LENGTH_BITS-9:0], data_byte};
               if (ext_left_ff != 3'd0) begin
                  ext_left_in = ext_left_ff - 3'd1;
               end else if (mask_present_ff) begin
                  idx_in   = '0;
                  phase_in = PHASE_MASK;
               end else begin
                  key_done = 1'b1;
               end
            end
            PHASE_MASK: begin
               key_in = {key_ff[23:0], data_byte};
               if (idx_ff != KeyLastIdx) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  key_done = 1'b1;
               end
            end
            PHASE_PAY: begin
               idx_in             = idx_ff + 2'd1;
               length_in          = len_dec;
               res_fire           = 1'b1;
               res.payload_byte   = data_byte ^ key_byte;
               res.frame_opcode   = opcode_ff;
               res.final_fragment = fin_ff;
               if (len_dec == '0) begin
                  res.last_of_frame = 1'b1;
                  phase_in          = PHASE_HDR0;
                  idx_in            = '0;
               end
            end
            default: begin
               phase_in = PHASE_HDR0;
            end
         endcase
         if (key_done) begin
            idx_in = '0;
            if (length_in == '0) begin
               phase_in           = PHASE_HDR0;
               res_fire           = 1'b1;
               res.frame_opcode   = opcode_ff;
               res.final_fragment = fin_ff;
               res.last_of_frame  = 1'b1;
               res.empty_frame    = 1'b1;
            end else begin
               phase_in = PHASE_PAY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_HDR0;
         fin_ff          <= 1'b0;
         opcode_ff       <= '0;
         mask_present_ff <= 1'b0;
         length_ff       <= '0;
         ext_left_ff     <= '0;
         key_ff          <= '0;
         idx_ff          <= '0;
         halted_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         fin_ff          <= fin_in;
         opcode_ff       <= opcode_in;
         mask_present_ff <= mask_present_in;
         length_ff       <= length_in;
         ext_left_ff     <= ext_left_in;
         key_ff          <= key_in;
         idx_ff          <= idx_in;
         halted_ff       <= halted_in;
      end
   end

   `WSD_ASSERT_NEXT(a_halt_sticks, clock, reset, halted_ff, halted_ff, "halt state was left without reset")
   `WSD_ASSERT_NEXT(a_error_halts, clock, reset, res_fire && res.reserved_bits_error, halted_ff, "reserved-bit error did not halt the parser")
   `WSD_ASSERT_NOW(a_empty_is_last, clock, reset, res_fire && res.empty_frame, res.last_of_frame && (res.payload_byte == 8'h00), "empty marker not flagged as last or carries data")

endmodule

[rtl/wsd_out_reg.sv]
// Result register that holds one beat for the response channel.
module wsd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  wsd_pkg::result_type res,
   output logic                can_take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wsd_pkg::result_type rsp_res
);
   import wsd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign can_take  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

endmodule

[rtl/websocket_frame_deframer_unmask_core.sv]
// WebSocket receive deframer: takes one stream byte per cycle, parses each frame header,
// unmasks the payload and emits one beat per payload byte, one marker beat per empty frame
// and one error beat when the reserved bits are set, after which it drops every byte until
// reset. A byte is taken into an input register, then parsed and unmasked, and its result
// lands in an output register that offers it on the response channel. The block sustains
// one byte per cycle; it stalls only while the output register holds a beat that the
// consumer does not take.
`include "websocket_frame_deframer_unmask_core_macros.svh"

module websocket_frame_deframer_unmask_core #(
   parameter int LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_final_fragment,
   output logic       rsp_last_of_frame,
   output logic       rsp_empty_frame,
   output logic       rsp_reserved_bits_error
);
   import wsd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       step;
   logic       can_take;
   logic       res_fire;
   result_type res;
   result_type rsp_res;

   assign step      = in_valid_ff && can_take;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   wsd_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .res_fire  (res_fire),
      .res       (res)
   );

   wsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && res_fire),
      .res       (res),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_payload_byte        = rsp_res.payload_byte;
   assign rsp_frame_opcode        = rsp_res.frame_opcode;
   assign rsp_final_fragment      = rsp_res.final_fragment;
   assign rsp_last_of_frame       = rsp_res.last_of_frame;
   assign rsp_empty_frame         = rsp_res.empty_frame;
   assign rsp_reserved_bits_error = rsp_res.reserved_bits_error;

   `WSD_ASSERT_NOW(a_error_beat_clean, clock, reset, rsp_valid && rsp_reserved_bits_error, (rsp_payload_byte == 8'h00) && (rsp_frame_opcode == 4'h0) && !rsp_last_of_frame, "error beat carries frame data")

endmodule

[test/testbench.sv]
// Self-checking testbench for the WebSocket receive deframer and unmasker.
`timescale 1ns / 1ps

module testbench;
   import wsd_pkg::*;

   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int LONG_HOLD      = 400;
   localparam int STUCK_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 10;
   localparam logic [6:0] LenExt64Code = 7'd127;

   typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_type;

   typedef struct packed {
      logic [7:0] data;
      logic       typed;
      result_type want;
   } stim_row_type;

   // A typed row carries its beat as {payload, opcode, fin, last, empty, error}.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      {8'h89, 1'b0, 16'h0000},
      {8'h00, 1'b1, 8'h00, 4'h9, 4'b1110},
      {8'h81, 1'b0, 16'h0000},
      {8'h81, 1'b0, 16'h0000},
      {8'hFF, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'hA5, 1'b0, 16'h0000},
      {8'h5A, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h88, 1'b0, 16'h0000},
      {8'h7E, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h00, 1'b1, 8'h00, 4'h8, 4'b1110},
      {8'h0F, 1'b0, 16'h0000},
      {8'h7F, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h00, 1'b0, 16'h0000},
      {8'h01, 1'b0, 16'h0000},
      {8'hAB, 1'b1, 8'hAB, 4'hF, 4'b0100}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_final_fragment;
   logic       rsp_last_of_frame;
   logic       rsp_empty_frame;
   logic       rsp_reserved_bits_error;

   phase_type   ws_phase = PHASE_HDR0;
   logic        ws_fin = 1'b0;
   logic [3:0]  ws_opcode = 4'h0;
   logic        ws_masked = 1'b0;
   logic [63:0] ws_len = 64'd0;
   logic [2:0]  ws_ext_left = 3'd0;
   logic [31:0] ws_key = 32'd0;
   logic [1:0]  ws_key_idx = 2'd0;
   logic        ws_halted = 1'b0;

   result_type expected_beats [$];
   int         bytes_fed = 0;
   int         frames_sent = 0;
   int         beats_seen = 0;
   int         markers_seen = 0;
   int         bad_beats = 0;
   int         stuck_cycles = 0;
   logic       steady_flow = 1'b0;
   logic       long_hold_req = 1'b0;

   websocket_frame_deframer_unmask_core DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_payload_byte       (rsp_payload_byte),
      .rsp_frame_opcode       (rsp_frame_opcode),
      .rsp_final_fragment     (rsp_final_fragment),
      .rsp_last_of_frame      (rsp_last_of_frame),
      .rsp_empty_frame        (rsp_empty_frame),
      .rsp_reserved_bits_error(rsp_reserved_bits_error)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic finish_header(output result_type r, input logic key_done);
      r = '0;
      if (ws_masked && !key_done) begin
         ws_key_idx = 2'd0;
         ws_phase = PHASE_MASK;
         return 1'b0;
      end
      ws_key_idx = 2'd0;
      if (ws_len == 64'd0) begin
         ws_phase = PHASE_HDR0;
         r.frame_opcode = ws_opcode;
         r.final_fragment = ws_fin;
         r.last_of_frame = 1'b1;
         r.empty_frame = 1'b1;
         return 1'b1;
      end
      ws_phase = PHASE_PAY;
      return 1'b0;
   endfunction

   function automatic logic deframe_step(input logic [7:0] b, output result_type r);
      logic [6:0] len7;
      logic [7:0] k;
      r = '0;
      if (ws_halted) return 1'b0;
      case (ws_phase)
         PHASE_HDR0: begin
            if ((b & RsvMask) != 8'h00) begin
               ws_halted = 1'b1;
               r.reserved_bits_error = 1'b1;
               return 1'b1;
            end
            ws_fin = b[7];
            ws_opcode = b[3:0];
            ws_phase = PHASE_HDR1;
            return 1'b0;
         end
         PHASE_HDR1: begin
            ws_masked = b[7];
            ws_key = 32'd0;
            ws_key_idx = 2'd0;
            len7 = b[6:0];
            if (len7 > LenShortMax) begin
               ws_len = 64'd0;
               ws_ext_left = (len7 == LenExt16) ? ExtBytes16 : ExtBytes64;
               ws_phase = PHASE_EXT;
               return 1'b0;
            end
            ws_len = 64'(len7);
            return finish_header(r, 1'b0);
         end
         PHASE_EXT: begin
            ws_len = {ws_len[55:0], b};
            if (ws_ext_left != 3'd0) begin
               ws_ext_left = ws_ext_left - 3'd1;
               return 1'b0;
            end
            return finish_header(r, 1'b0);
         end
         PHASE_MASK: begin
            ws_key = {ws_key[23:0], b};
            if (ws_key_idx != KeyLastIdx) begin
               ws_key_idx = ws_key_idx + 2'd1;
               return 1'b0;
            end
            return finish_header(r, 1'b1);
         end
         PHASE_PAY: begin
            k = 8'(ws_key >> (24 - 8 * int'(ws_key_idx)));
            ws_key_idx = ws_key_idx + 2'd1;
            ws_len = ws_len - 64'd1;
            r.payload_byte = b ^ k;
            r.frame_opcode = ws_opcode;
            r.final_fragment = ws_fin;
            r.last_of_frame = (ws_len == 64'd0);
            if (ws_len == 64'd0) begin
               ws_phase = PHASE_HDR0;
               ws_key_idx = 2'd0;
            end
            return 1'b1;
         end
         default: ws_phase = PHASE_HDR0;
      endcase
      return 1'b0;
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic typed, input result_type want);
      result_type predicted;
      logic produced;
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = deframe_step(b, predicted);
      if (typed) expected_beats.push_back(want);
      else if (produced) expected_beats.push_back(predicted);
      bytes_fed++;
   endtask

   task automatic idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_flow || pick < 70) return;
      req_valid <= 1'b0;
      if (pick < 95) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 40)) @(posedge clock);
   endtask

   task automatic feed_byte(input logic [7:0] b);
      push_byte(b, 1'b0, '0);
      idle_gap();
   endtask

   task automatic send_frame(input int len, input len_form_type form, input logic masked);
      logic [63:0] len64;
      len64 = 64'(len);
      feed_byte({1'($urandom), 3'b000, 4'($urandom)});
      case (form)
         LEN_SHORT: feed_byte({masked, len64[6:0]});
         LEN_EXT16: begin
            feed_byte({masked, LenExt16});
            feed_byte(len64[15:8]);
            feed_byte(len64[7:0]);
         end
         default: begin
            feed_byte({masked, LenExt64Code});
            for (int i = 7; i >= 0; i--) feed_byte(len64[8 * i +: 8]);
         end
      endcase
      if (masked) repeat (4) feed_byte(8'($urandom));
      repeat (len) feed_byte(8'($urandom));
   endtask

   task automatic drain_expected();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
   endtask

   always @(posedge clock) begin : beat_check
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_payload_byte, rsp_frame_opcode, rsp_final_fragment, rsp_last_of_frame,
                rsp_empty_frame, rsp_reserved_bits_error};
         beats_seen++;
         if (got.empty_frame === 1'b1) markers_seen++;
         if (expected_beats.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
               $display("%0t: unexpected beat byte %h op %h fin %b last %b empty %b err %b",
                        $time, got.payload_byte, got.frame_opcode, got.final_fragment,
                        got.last_of_frame, got.empty_frame, got.reserved_bits_error);
         end else begin
            want = expected_beats.pop_front();
            if (got.payload_byte !== want.payload_byte
                  || got.frame_opcode !== want.frame_opcode
                  || got.final_fragment !== want.final_fragment
                  || got.last_of_frame !== want.last_of_frame
                  || got.empty_frame !== want.empty_frame
                  || got.reserved_bits_error !== want.reserved_bits_error) begin
               bad_beats++;
               if (bad_beats <= 10) begin
                  $display("%0t: expected byte %h op %h fin %b last %b empty %b err %b",
                           $time, want.payload_byte, want.frame_opcode, want.final_fragment,
                           want.last_of_frame, want.empty_frame, want.reserved_bits_error);
                  $display("%0t:      got byte %h op %h fin %b last %b empty %b err %b",
                           $time, got.payload_byte, got.frame_opcode, got.final_fragment,
                           got.last_of_frame, got.empty_frame, got.reserved_bits_error);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("No beat moved on either side for %0d cycles.", STUCK_LIMIT);
         $display("** websocket_frame_deframer_unmask_core: FAILED **");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : consumer
      int pick;
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (steady_flow || pick < 70) begin
               rsp_ready <= 1'b1;
               span = $urandom_range(1, 8);
            end else if (pick < 95) begin
               rsp_ready <= 1'b0;
               span = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               span = $urandom_range(10, 40);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : producer
      int pick;
      int len;
      len_form_type form;
      logic masked;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
         idle_gap();
      end

      while (bytes_fed < DIRECTED_COUNT + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         masked = ($urandom_range(0, 99) < 60);
         if (pick < 10) begin
            len = 0;
            form = len_form_type'($urandom_range(0, 2));
         end else if (pick < 50) begin
            len = $urandom_range(1, 8);
            form = LEN_SHORT;
         end else if (pick < 75) begin
            len = $urandom_range(0, 125);
            form = LEN_SHORT;
         end else if (pick < 88) begin
            len = $urandom_range(0, 300);
            form = LEN_EXT16;
         end else begin
            len = $urandom_range(0, 300);
            form = LEN_EXT64;
         end
         if (frames_sent == 12) begin
            long_hold_req = 1'b1;
            len = 120;
            form = LEN_SHORT;
         end
         if (frames_sent == 25) drain_expected();
         steady_flow = (frames_sent >= 30 && frames_sent < 40);
         send_frame(len, form, masked);
         frames_sent++;
      end
      steady_flow = 1'b0;

      // Reserved bits halt the block for good, so this comes last.
      push_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)}, 1'b1,
                {8'h00, 4'h0, 4'b0001});
      idle_gap();
      repeat (4) feed_byte(8'($urandom));

      drain_expected();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d random frames after the directed header cases;",
               bytes_fed, frames_sent);
      $display("checked %0d beats, %0d of them empty markers, ending with a halt on RSV bits.",
               beats_seen, markers_seen);
      if (expected_beats.size() != 0)
         $display("%0d expected beats never arrived.", expected_beats.size());
      if (bad_beats == 0 && expected_beats.size() == 0) begin
         $display("** websocket_frame_deframer_unmask_core: PASSED **");
      end else begin
         $display("** websocket_frame_deframer_unmask_core: FAILED **");
      end
      $finish;
   end

endmodule
